FILE: hdl/gelu_pkg.sv
package gelu_pkg;

   // Defaults for the sample format (signed Q5.11).
   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 11;

   // The polynomial and the sigmoid run in Q.16.
   localparam int IQ        = 16;
   localparam int SAT_LIMIT = 8;

   // Widths of the Q.16 intermediates. The input is clamped to +/-8, so:
   // xq within +/-2^19, x2 up to 2^22, x3 within +/-2^25, the inner sum
   // and the sigmoid argument within +/-2^22.
   localparam int Q_W  = IQ + 5;
   localparam int X2_W = IQ + 8;
   localparam int X3_W = IQ + 11;
   localparam int IN_W = IQ + 7;
   localparam int U_W  = IQ + 7;
   localparam int S_W  = IQ + 1;

   // 0.044715 and 2*sqrt(2/pi) in Q.16.
   localparam int COEF_CUBE  = 2930;
   localparam int CUBE_W     = 13;
   localparam int COEF_SCALE = 104580;
   localparam int SCALE_W    = 18;

   // Sigmoid table: 33 points at steps of 0.25 over [0, 8], Q.16.
   localparam int SEG_SHIFT = IQ - 2;
   localparam int SEG_IDX_W = 5;
   localparam int TAB_W     = 16;
   localparam int TAB_N     = 33;
   localparam logic [TAB_W-1:0] SIG_TAB [TAB_N] = '{
      16'd32768, 16'd36843, 16'd40793, 16'd44511, 16'd47911, 16'd50941,
      16'd53581, 16'd55834, 16'd57724, 16'd59287, 16'd60565, 16'd61598,
      16'd62428, 16'd63090, 16'd63615, 16'd64030, 16'd64357, 16'd64614,
      16'd64816, 16'd64974, 16'd65097, 16'd65194, 16'd65269, 16'd65328,
      16'd65374, 16'd65410, 16'd65438, 16'd65459, 16'd65476, 16'd65489,
      16'd65500, 16'd65508, 16'd65514
   };

   // Pipeline layout.
   localparam int POLY_STAGES = 5;
   localparam int SIGM_STAGES = 2;
   localparam int NUM_STAGES  = POLY_STAGES + SIGM_STAGES + 1;

endpackage

FILE: hdl/gelu_req_if.sv
interface gelu_req_if #(
   parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sample;
   logic                         last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

FILE: hdl/gelu_rsp_if.sv
interface gelu_rsp_if #(
   parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] activation;
   logic                         last_out;

   modport source (output valid, output activation, output last_out, input ready);
   modport sink   (input valid, input activation, input last_out, output ready);
endinterface

FILE: hdl/gelu_tanh_activation.sv
// GELU activation, tanh form, on a stream of signed fixed-point samples.
// Words arrive on req (sample, last) under a valid/ready handshake and leave
// on rsp (activation, last_out) in the same order, one result per sample;
// last is copied through unchanged.
// The datapath is an eight-stage pipeline: clamp and conversion, square,
// cube, cubic term, scaling, sigmoid table lookup with interpolation product,
// sigmoid combine, and final multiply with rounding and clipping, which is
// also the output register. An accepted word passes through these stages
// in order and is shown on rsp from the last of them. One word is taken
// per cycle while nothing stalls. Every stage has its own valid bit and
// loads when it is empty or its successor moves, so bubbles close up and
// req.ready falls only once all eight stages hold words while rsp stalls;
// nothing is lost or repeated. Reset clears the valid bits only; the data
// registers are not reset, and the block has no configuration.
module gelu_tanh_activation #(
   parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = gelu_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   gelu_req_if.sink     req,
   gelu_rsp_if.source   rsp
);
   import gelu_pkg::*;

   localparam int SIGM_LO = POLY_STAGES;
   localparam int OUT_ST  = NUM_STAGES - 1;

   logic [NUM_STAGES-1:0]         stage_en;
   logic [NUM_STAGES-1:0]         valid_in, valid_ff;
   logic signed [DATA_WIDTH-1:0]  x_ff [NUM_STAGES-1];
   logic [NUM_STAGES-1:0]         last_ff;
   logic signed [U_W-1:0]         u;
   logic [S_W-1:0]                sig;
   logic signed [DATA_WIDTH-1:0]  y;

   always_comb begin
      stage_en[OUT_ST] = !valid_ff[OUT_ST] || rsp.ready;
      for (int k = OUT_ST - 1; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = req.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // The sample and the last flag ride alongside the datapath.
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         x_ff[0]    <= req.sample;
         last_ff[0] <= req.last;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (stage_en[k]) begin
            last_ff[k] <= last_ff[k-1];
         end
      end
      for (int k = 1; k < OUT_ST; k++) begin
         if (stage_en[k]) begin
            x_ff[k] <= x_ff[k-1];
         end
      end
   end

   gelu_poly #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_poly (
      .clock    (clock),
      .stage_en (stage_en[POLY_STAGES-1:0]),
      .sample   (req.sample),
      .u        (u)
   );

   gelu_sigm u_sigm (
      .clock    (clock),
      .stage_en (stage_en[SIGM_LO+SIGM_STAGES-1:SIGM_LO]),
      .u        (u),
      .sig      (sig)
   );

   gelu_scale #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_scale (
      .clock    (clock),
      .stage_en (stage_en[OUT_ST]),
      .x        (x_ff[OUT_ST-1]),
      .sig      (sig),
      .y        (y)
   );

   assign req.ready      = stage_en[0];
   assign rsp.valid      = valid_ff[OUT_ST];
   assign rsp.activation = y;
   assign rsp.last_out   = last_ff[OUT_ST];

endmodule

FILE: hdl/gelu_poly.sv
module gelu_poly #(
   parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = gelu_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic [gelu_pkg::POLY_STAGES-1:0]   stage_en,
   input  logic signed [DATA_WIDTH-1:0]       sample,
   output logic signed [gelu_pkg::U_W-1:0]    u
);
   import gelu_pkg::*;

   localparam int CW = (DATA_WIDTH > FRAC_BITS + 5) ? DATA_WIDTH : FRAC_BITS + 5;
   localparam int SW = CW + IQ;
   localparam logic signed [CW-1:0] LIM = CW'(longint'(SAT_LIMIT) << FRAC_BITS);
   localparam logic signed [CUBE_W-1:0]  K_CUBE  = CUBE_W'(COEF_CUBE);
   localparam logic signed [SCALE_W-1:0] K_SCALE = SCALE_W'(COEF_SCALE);

   logic signed [CW-1:0]             x_ext;
   logic signed [CW-1:0]             x_clamp;
   logic signed [SW-1:0]             x_wide;
   logic signed [SW-1:0]             x_q16;
   logic signed [Q_W-1:0]            xq1_ff, xq2_ff, xq3_ff;
   logic signed [2*Q_W-1:0]          sq_prod;
   logic signed [X2_W-1:0]           x2_ff;
   logic signed [X2_W+Q_W-1:0]       cube_prod;
   logic signed [X3_W-1:0]           x3_ff;
   logic signed [X3_W+CUBE_W-1:0]    term_prod;
   logic signed [IN_W-1:0]           term;
   logic signed [IN_W-1:0]           inner_in, inner_ff;
   logic signed [IN_W+SCALE_W-1:0]   u_prod;
   logic signed [U_W-1:0]            u_ff;

   // Clamp to +/-8 and bring the sample into Q.16.
   assign x_ext   = CW'(sample);
   assign x_clamp = (x_ext > LIM) ? LIM : ((x_ext < -LIM) ? -LIM : x_ext);
   assign x_wide  = SW'(x_clamp);

   generate
      if (FRAC_BITS >= IQ) begin : g_down
         assign x_q16 = x_wide >>> (FRAC_BITS - IQ);
      end else begin : g_up
         assign x_q16 = x_wide <<< (IQ - FRAC_BITS);
      end
   endgenerate

   assign sq_prod   = xq1_ff * xq1_ff;
   assign cube_prod = x2_ff * xq2_ff;
   assign term_prod = x3_ff * K_CUBE;
   assign term      = $signed(term_prod[IQ+IN_W-1:IQ]);
   assign inner_in  = IN_W'(xq3_ff) + term;
   assign u_prod    = inner_ff * K_SCALE;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         xq1_ff <= x_q16[Q_W-1:0];
      end
      if (stage_en[1]) begin
         x2_ff  <= $signed(sq_prod[IQ+X2_W-1:IQ]);
         xq2_ff <= xq1_ff;
      end
      if (stage_en[2]) begin
         x3_ff  <= $signed(cube_prod[IQ+X3_W-1:IQ]);
         xq3_ff <= xq2_ff;
      end
      if (stage_en[3]) begin
         inner_ff <= inner_in;
      end
      if (stage_en[4]) begin
         u_ff <= $signed(u_prod[IQ+U_W-1:IQ]);
      end
   end

   assign u = u_ff;

endmodule

FILE: hdl/gelu_sigm.sv
module gelu_sigm (
   input  logic                              clock,
   input  logic [gelu_pkg::SIGM_STAGES-1:0]  stage_en,
   input  logic signed [gelu_pkg::U_W-1:0]   u,
   output logic [gelu_pkg::S_W-1:0]          sig
);
   import gelu_pkg::*;

   localparam int PROD_W = TAB_W + SEG_SHIFT;
   localparam logic [S_W-1:0] ONE = S_W'(longint'(1) << IQ);

   logic [U_W-1:0]        mag;
   logic                  neg;
   logic                  sat;
   logic [SEG_IDX_W-1:0]  seg;
   logic [SEG_SHIFT-1:0]  frac;
   logic [TAB_W-1:0]      lo, hi, diff;
   logic [PROD_W-1:0]     interp_prod;
   logic [TAB_W-1:0]      base_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic                  neg_ff, sat_ff;
   logic [PROD_W-1:0]     step;
   logic [S_W-1:0]        s_lin, s_sel, sig_in, sig_ff;

   // The sigmoid is looked up on |u|; the negative side is 1 - s.
   assign neg  = u[U_W-1];
   assign mag  = neg ? U_W'(-u) : U_W'(u);
   assign sat  = |mag[U_W-1:IQ+3];
   assign seg  = mag[IQ+2:SEG_SHIFT];
   assign frac = mag[SEG_SHIFT-1:0];
   assign lo   = SIG_TAB[seg];
   assign hi   = SIG_TAB[{1'b0, seg} + 6'd1];
   assign diff = hi - lo;
   assign interp_prod = diff * frac;

   assign step   = (prod_ff + PROD_W'(longint'(1) << (SEG_SHIFT - 1))) >> SEG_SHIFT;
   assign s_lin  = S_W'(base_ff) + step[S_W-1:0];
   assign s_sel  = sat_ff ? ONE : s_lin;
   assign sig_in = neg_ff ? (ONE - s_sel) : s_sel;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         base_ff <= lo;
         prod_ff <= interp_prod;
         neg_ff  <= neg;
         sat_ff  <= sat;
      end
      if (stage_en[1]) begin
         sig_ff <= sig_in;
      end
   end

   assign sig = sig_ff;

endmodule

FILE: hdl/gelu_scale.sv
module gelu_scale #(
   parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          stage_en,
   input  logic signed [DATA_WIDTH-1:0]  x,
   input  logic [gelu_pkg::S_W-1:0]      sig,
   output logic signed [DATA_WIDTH-1:0]  y
);
   import gelu_pkg::*;

   localparam int PW = DATA_WIDTH + S_W + 1;
   localparam int YW = DATA_WIDTH + 2;
   localparam logic signed [YW-1:0] MAXV = YW'((longint'(1) << (DATA_WIDTH - 1)) - 1);
   localparam logic signed [YW-1:0] MINV = YW'(-(longint'(1) << (DATA_WIDTH - 1)));
   localparam logic signed [PW-1:0] HALF = PW'(longint'(1) << (IQ - 1));

   logic signed [PW-1:0]          prod;
   logic signed [PW-1:0]          rounded;
   logic signed [YW-1:0]          y_full;
   logic signed [DATA_WIDTH-1:0]  y_in, y_ff;

   // Round half up, then clip to the sample range.
   assign prod    = x * $signed({1'b0, sig});
   assign rounded = prod + HALF;
   assign y_full  = $signed(rounded[IQ+YW-1:IQ]);
   assign y_in    = (y_full > MAXV) ? MAXV[DATA_WIDTH-1:0] :
                    ((y_full < MINV) ? MINV[DATA_WIDTH-1:0] : y_full[DATA_WIDTH-1:0]);

   always_ff @(posedge clock) begin
      if (stage_en) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

FILE: tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gelu_pkg::*;

   localparam int DW   = DATA_WIDTH_DEF;
   localparam int FRAC = FRAC_BITS_DEF;

   // Internal precision of the polynomial and of the sigmoid.
   localparam longint Q_FRAC     = 16;
   localparam longint ONE_Q16    = 64'd1 << Q_FRAC;
   localparam longint CUBIC_COEF = 2930;
   localparam longint SCALE_COEF = 104580;
   localparam longint SIG_LIMIT  = 8;
   localparam longint CLAMP      = SIG_LIMIT << FRAC;
   localparam longint MAX_VAL    = (64'd1 << (DW - 1)) - 1;
   localparam longint MIN_VAL    = -(64'sd1 << (DW - 1));

   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_REPORTS  = 10;

   // Sigmoid at steps of 0.25 over [0, 8], Q.16.
   localparam int SIGMOID_Q16 [33] = '{
      32768, 36843, 40793, 44511, 47911, 50941, 53581, 55834,
      57724, 59287, 60565, 61598, 62428, 63090, 63615, 64030,
      64357, 64614, 64816, 64974, 65097, 65194, 65269, 65328,
      65374, 65410, 65438, 65459, 65476, 65489, 65500, 65508,
      65514
   };

   typedef struct {
      logic signed [DW-1:0] activation;
      logic                 last;
   } gelu_word_type;

   logic clock;
   logic reset;

   gelu_req_if #(.DATA_WIDTH(DW)) req_bus ();
   gelu_rsp_if #(.DATA_WIDTH(DW)) rsp_bus ();

   gelu_tanh_activation #(
      .DATA_WIDTH (DW),
      .FRAC_BITS  (FRAC)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   gelu_word_type pending_results [$];
   int            mismatches;
   bit            gaps_on;
   bit            stalls_on;
   bit            hold_off;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1ms;
      $display("gelu_tanh_activation regression: fail");
      $finish;
   end

   // GELU of one Q5.11 sample: clamp, cubic in Q.16, interpolated sigmoid,
   // then x times sigmoid rounded half up and clipped.
   function automatic logic signed [DW-1:0] gelu_q511(input logic signed [DW-1:0] x);
      longint xv, xc, xq, sq, cube, poly, arg, mag, sig, seg, frac, y;
      xv = x;
      xc = xv;
      if (xc > CLAMP) xc = CLAMP;
      if (xc < -CLAMP) xc = -CLAMP;
      xq = xc <<< (Q_FRAC - FRAC);
      sq = (xq * xq) >>> Q_FRAC;
      cube = (sq * xq) >>> Q_FRAC;
      poly = xq + ((CUBIC_COEF * cube) >>> Q_FRAC);
      arg = (SCALE_COEF * poly) >>> Q_FRAC;
      mag = (arg < 0) ? -arg : arg;
      if (mag >= (SIG_LIMIT << Q_FRAC)) begin
         sig = ONE_Q16;
      end else begin
         seg = mag >>> (Q_FRAC - 2);
         frac = mag & 64'h3FFF;
         sig = SIGMOID_Q16[seg]
               + (((SIGMOID_Q16[seg + 1] - SIGMOID_Q16[seg]) * frac + 64'h2000) >>> 14);
      end
      if (arg < 0) sig = ONE_Q16 - sig;
      y = (xv * sig + (ONE_Q16 >>> 1)) >>> Q_FRAC;
      if (y > MAX_VAL) y = MAX_VAL;
      if (y < MIN_VAL) y = MIN_VAL;
      return y[DW-1:0];
   endfunction

   function automatic logic signed [DW-1:0] pick_sample();
      case ($urandom_range(0, 3))
         0: return DW'($urandom);
         1: return DW'($signed($urandom_range(0, 16384)) - 8192);
         2: return DW'($signed($urandom_range(0, 2048)) - 1024);
         default: return DW'(($urandom_range(0, 1) ? 1 : -1)
                             * $signed($urandom_range(6000, 17000)));
      endcase
   endfunction

   task automatic note_mismatch(input string msg);
      if (mismatches < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // Offers one word and returns at the falling edge after it is taken.
   task automatic send_sample(input logic signed [DW-1:0] x, input logic last);
      gelu_word_type want;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_bus.valid  = 1'b1;
      req_bus.sample = x;
      req_bus.last   = last;
      do @(posedge clock); while (!req_bus.ready);
      want.activation = gelu_q511(x);
      want.last       = last;
      pending_results.push_back(want);
      @(negedge clock);
   endtask

   task automatic test_extremes();
      logic signed [DW-1:0] points [$];
      points = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sd16384,
                 -16'sd16384, 16'sd16385, -16'sd16385, 16'sd16383, -16'sd16383,
                 16'sd2048, -16'sd2048, 16'sh5555, 16'shAAAA};
      foreach (points[i]) send_sample(points[i], i[0]);
   endtask

   // The sigmoid argument reaches its saturation limit near |x| = 3.34.
   task automatic test_saturation_knee();
      for (int k = 0; k < 5; k++) begin
         send_sample(DW'(6800 + 20 * k), 1'b0);
         send_sample(DW'(-6800 - 20 * k), 1'b1);
      end
   endtask

   task automatic test_random_with_idling(input int count);
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      repeat (count) send_sample(pick_sample(), 1'($urandom));
   endtask

   // The receiver holds off while words keep coming, so the pipeline fills
   // and the input must stall until the hold ends.
   task automatic test_backpressure(input int count);
      gaps_on = 1'b0;
      hold_off = 1'b1;
      repeat (count) send_sample(pick_sample(), 1'($urandom));
   endtask

   task automatic test_full_rate(input int count);
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      repeat (count) send_sample(pick_sample(), 1'($urandom));
   endtask

   // Result side: random stall bursts, plus one long hold when asked.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready = 1'b0;
         end else if (hold_off) begin
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_off = 1'b0;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      gelu_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            note_mismatch($sformatf("word with nothing expected: activation %0d last %0b",
                                    rsp_bus.activation, rsp_bus.last_out));
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.activation !== want.activation)
               note_mismatch($sformatf("activation: expected %0d, got %0d",
                                       want.activation, rsp_bus.activation));
            if (rsp_bus.last_out !== want.last)
               note_mismatch($sformatf("last_out: expected %0b, got %0b",
                                       want.last, rsp_bus.last_out));
         end
      end
   end

   initial begin
      mismatches = 0;
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      hold_off = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      req_bus.last = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_saturation_knee();
      test_random_with_idling(280);
      test_backpressure(40);
      test_random_with_idling(40);
      test_full_rate(60);
      req_bus.valid = 1'b0;

      wait (pending_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("gelu_tanh_activation regression: pass");
      end else begin
         $display("gelu_tanh_activation regression: fail");
      end
      $finish;
   end

endmodule
